// ===== sv/switch_request_router_defines.svh =====
// Shared assertion macros for the switch request router checks
`ifndef SWITCH_REQUEST_ROUTER_DEFINES_SVH
`define SWITCH_REQUEST_ROUTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define SRR_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("switch_request_router check failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define SRR_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("switch_request_router check failed");

`endif

// ===== sv/srr_pkg.sv =====
package srr_pkg;

  // Default sizes
  localparam int SWITCH_COUNT_DEF  = 2048;
  localparam int EXACT_ENTRIES_DEF = 32;
  localparam int RANGE_ENTRIES_DEF = 16;

  // Field widths
  localparam int ADDR_W = 12;
  localparam int SUB_W  = 8;
  localparam int SLOT_W = 5;
  localparam int CFG_W  = 6;

  // Configuration register indexes
  localparam logic CFG_EXACT_COUNT = 1'b0;
  localparam logic CFG_RANGE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_REQUEST    = 2'd0,
    KIND_QUERY      = 2'd1,
    KIND_LOAD_EXACT = 2'd2,
    KIND_LOAD_RANGE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_EXACT = 2'd0,
    RES_RANGE = 2'd1,
    RES_STATE = 2'd2,
    RES_DONE  = 2'd3
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_EXACT,
    ST_RANGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    result_kind_t       result_kind;
    logic [SUB_W-1:0]   subscriber;
    logic [ADDR_W-1:0]  switch_address;
    logic               switch_direction;
    logic               state_bit;
    logic               last;
  } out_beat_t;

endpackage

// ===== sv/switch_request_router.sv =====
// Load: no result. Query: reply beat from the query state once the output slot
// is free. Request: with on_flag, walks exact_count then range_count entries
// (counts clamped to table depth), one entry per cycle through a shared compare
// unit unless a hit waits on a stalled output, then a finished beat. in_ready
// rises in the cycle after the last result is loaded. Reset (rst, synchronous):
// clears counts, then sweeps all direction entries one a cycle, in_ready low.
module switch_request_router #(
  parameter int SWITCH_COUNT  = srr_pkg::SWITCH_COUNT_DEF,
  parameter int EXACT_ENTRIES = srr_pkg::EXACT_ENTRIES_DEF,
  parameter int RANGE_ENTRIES = srr_pkg::RANGE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [srr_pkg::CFG_W-1:0]  cfg_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [srr_pkg::ADDR_W-1:0] address,
  input  logic                       direction,
  input  logic                       on_flag,
  input  logic [srr_pkg::SLOT_W-1:0] entry_slot,
  input  logic [srr_pkg::ADDR_W-1:0] range_first,
  input  logic [srr_pkg::ADDR_W-1:0] range_last,
  input  logic [srr_pkg::SUB_W-1:0]  subscriber_id,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 result_kind,
  output logic [srr_pkg::SUB_W-1:0]  subscriber,
  output logic [srr_pkg::ADDR_W-1:0] switch_address,
  output logic                       switch_direction,
  output logic                       state_bit,
  output logic                       last
);

  localparam int AW  = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
  localparam int EIW = (EXACT_ENTRIES > 1) ? $clog2(EXACT_ENTRIES) : 1;
  localparam int RIW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
  localparam int ECW = $clog2(EXACT_ENTRIES + 1);
  localparam int RCW = $clog2(RANGE_ENTRIES + 1);
  localparam int IW  = (ECW > RCW) ? ECW : RCW;

  srr_pkg::state_t state, state_next;

  logic [AW-1:0]  clr_idx;
  logic [IW-1:0]  idx, idx_next;
  logic [ECW-1:0] exact_lim;
  logic [RCW-1:0] range_lim;

  logic [srr_pkg::ADDR_W-1:0] req_addr;
  logic                       req_dir;
  logic                       req_ok;
  logic                       rd_bit;

  logic dir_mem [SWITCH_COUNT];

  logic [srr_pkg::ADDR_W-1:0] ex_addr [EXACT_ENTRIES];
  logic [srr_pkg::SUB_W-1:0]  ex_sub  [EXACT_ENTRIES];
  logic [srr_pkg::ADDR_W-1:0] rg_low  [RANGE_ENTRIES];
  logic [srr_pkg::ADDR_W-1:0] rg_high [RANGE_ENTRIES];
  logic [srr_pkg::SUB_W-1:0]  rg_sub  [RANGE_ENTRIES];

  logic                       in_fire;
  logic                       addr_ok;
  logic [AW-1:0]              dir_idx;
  logic                       slot_free;
  logic                       out_load;
  srr_pkg::out_beat_t         beat_next, beat;
  logic [srr_pkg::ADDR_W-1:0] cmp_lo, cmp_hi;
  logic                       hit;

  assign in_ready  = (state == srr_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign addr_ok   = (address != '0) && (32'(address) <= SWITCH_COUNT);
  assign dir_idx   = AW'(address - srr_pkg::ADDR_W'(1));
  assign slot_free = !out_valid || out_ready;

  // Configuration registers, clamped to the table depth (range count from cfg_data[4:0])
  always_ff @(posedge clk) begin
    if (rst) begin
      exact_lim <= '0;
      range_lim <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srr_pkg::CFG_EXACT_COUNT: begin
          exact_lim <= (32'(cfg_data) > EXACT_ENTRIES) ? ECW'(EXACT_ENTRIES)
                                                       : cfg_data[ECW-1:0];
        end
        srr_pkg::CFG_RANGE_COUNT: begin
          range_lim <= (32'(cfg_data[4:0]) > RANGE_ENTRIES) ? RCW'(RANGE_ENTRIES)
                                                            : cfg_data[RCW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Direction memory: clear sweep, request write, query read
  always_ff @(posedge clk) begin
    if (state == srr_pkg::ST_CLEAR) begin
      dir_mem[clr_idx] <= 1'b0;
    end else if (in_fire && kind == srr_pkg::KIND_REQUEST && on_flag && addr_ok) begin
      dir_mem[dir_idx] <= direction;
    end
    if (in_fire) begin
      rd_bit <= dir_mem[dir_idx];
    end
  end

  // Subscriber tables, written by load beats
  always_ff @(posedge clk) begin
    if (in_fire && kind == srr_pkg::KIND_LOAD_EXACT && 32'(entry_slot) < EXACT_ENTRIES) begin
      ex_addr[entry_slot[EIW-1:0]] <= address;
      ex_sub[entry_slot[EIW-1:0]]  <= subscriber_id;
    end
    if (in_fire && kind == srr_pkg::KIND_LOAD_RANGE && 32'(entry_slot) < RANGE_ENTRIES) begin
      rg_low[entry_slot[RIW-1:0]]  <= range_first;
      rg_high[entry_slot[RIW-1:0]] <= range_last;
      rg_sub[entry_slot[RIW-1:0]]  <= subscriber_id;
    end
  end

  // Capture the request or query
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_addr <= address;
      req_dir  <= direction;
      req_ok   <= addr_ok;
    end
  end

  // Sequencer state, walk index and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= srr_pkg::ST_CLEAR;
      idx     <= '0;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (state == srr_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  // Shared compare unit: address within [cmp_lo, cmp_hi]
  always_comb begin
    if (state == srr_pkg::ST_RANGE) begin
      cmp_lo = rg_low[idx[RIW-1:0]];
      cmp_hi = rg_high[idx[RIW-1:0]];
    end else begin
      cmp_lo = ex_addr[idx[EIW-1:0]];
      cmp_hi = ex_addr[idx[EIW-1:0]];
    end
    hit = (req_addr >= cmp_lo) && (req_addr <= cmp_hi);
  end

  // Next state and result beats
  always_comb begin
    state_next = state;
    idx_next   = idx;
    out_load   = 1'b0;
    beat_next.result_kind      = srr_pkg::RES_DONE;
    beat_next.subscriber       = '0;
    beat_next.switch_address   = req_addr;
    beat_next.switch_direction = req_dir;
    beat_next.state_bit        = 1'b0;
    beat_next.last             = 1'b0;
    unique case (state)
      srr_pkg::ST_CLEAR: begin
        if (clr_idx == AW'(SWITCH_COUNT - 1)) begin
          state_next = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_IDLE: begin
        idx_next = '0;
        if (in_fire) begin
          if (kind == srr_pkg::KIND_QUERY) begin
            state_next = srr_pkg::ST_QUERY;
          end else if (kind == srr_pkg::KIND_REQUEST) begin
            state_next = on_flag ? srr_pkg::ST_EXACT : srr_pkg::ST_DONE;
          end
        end
      end
      srr_pkg::ST_QUERY: begin
        beat_next.result_kind      = srr_pkg::RES_STATE;
        beat_next.switch_direction = 1'b0;
        beat_next.state_bit        = req_ok && rd_bit;
        beat_next.last             = 1'b1;
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_EXACT: begin
        beat_next.result_kind = srr_pkg::RES_EXACT;
        beat_next.subscriber  = ex_sub[idx[EIW-1:0]];
        if (idx >= IW'(exact_lim)) begin
          idx_next   = '0;
          state_next = srr_pkg::ST_RANGE;
        end else if (!hit) begin
          idx_next = idx + IW'(1);
        end else if (slot_free) begin
          out_load = 1'b1;
          idx_next = idx + IW'(1);
        end
      end
      srr_pkg::ST_RANGE: begin
        beat_next.result_kind = srr_pkg::RES_RANGE;
        beat_next.subscriber  = rg_sub[idx[RIW-1:0]];
        if (idx >= IW'(range_lim)) begin
          state_next = srr_pkg::ST_DONE;
        end else if (!hit) begin
          idx_next = idx + IW'(1);
        end else if (slot_free) begin
          out_load = 1'b1;
          idx_next = idx + IW'(1);
        end
      end
      srr_pkg::ST_DONE: begin
        beat_next.last = 1'b1;
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = srr_pkg::ST_IDLE;
        end
      end
      default: state_next = srr_pkg::ST_IDLE;
    endcase
  end

  // Output register: hold until taken, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      beat <= beat_next;
    end
  end

  assign result_kind      = beat.result_kind;
  assign subscriber       = beat.subscriber;
  assign switch_address   = beat.switch_address;
  assign switch_direction = beat.switch_direction;
  assign state_bit        = beat.state_bit;
  assign last             = beat.last;

endmodule

// ===== sv/srr_checker.sv =====
`include "switch_request_router_defines.svh"

module srr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 result_kind,
  input logic [srr_pkg::SUB_W-1:0]  subscriber,
  input logic [srr_pkg::ADDR_W-1:0] switch_address,
  input logic                       switch_direction,
  input logic                       state_bit,
  input logic                       last
);

  // A stalled result beat holds its kind, subscriber, address and last flag
  `SRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(subscriber) && $stable(switch_address) && $stable(last))

  // Only state replies and finished beats close an item
  `SRR_ASSERT_IMPLY(a_last_kind, out_valid, last == (result_kind == srr_pkg::RES_STATE || result_kind == srr_pkg::RES_DONE))

  // State replies carry no subscriber and no direction
  `SRR_ASSERT_IMPLY(a_state_reply, out_valid && result_kind == srr_pkg::RES_STATE, subscriber == '0 && switch_direction == 1'b0)

  // Finished beats carry no subscriber and no state bit
  `SRR_ASSERT_IMPLY(a_done_beat, out_valid && result_kind == srr_pkg::RES_DONE, subscriber == '0 && state_bit == 1'b0)

endmodule

bind switch_request_router srr_checker u_srr_checker (.*);

// ===== tb/tb_switch_request_router.sv =====
`timescale 1ns / 100ps

module tb_switch_request_router;
  import srr_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 64;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam int PHASE_ITEMS = 14;
  localparam int PHASE_COUNT = 7;
  localparam int FIXED_PHASES = 5;
  localparam int PHASE_EXACT [FIXED_PHASES] = '{32, 1, 0, 32, 63};
  localparam int PHASE_RANGE [FIXED_PHASES] = '{16, 1, 16, 0, 31};
  localparam int QUIET_PHASE = 2;
  localparam int IDLE_PCT = 21;
  localparam int DIRECTED_ROW_COUNT = 27;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic               direction;
    logic               on_flag;
    logic [SLOT_W-1:0]  entry_slot;
    logic [ADDR_W-1:0]  range_first;
    logic [ADDR_W-1:0]  range_last;
    logic [SUB_W-1:0]   subscriber_id;
    logic               typed;
    out_beat_t          result;
  } switch_item_t;

  typedef enum logic {
    ROW_SEND,
    ROW_COUNTS
  } row_op_t;

  typedef struct packed {
    row_op_t      op;
    logic [5:0]   exact_n;
    logic [5:0]   range_n;
    switch_item_t item;
  } directed_row_t;

  localparam out_beat_t NO_BEAT = '0;
  localparam switch_item_t NO_ITEM = '0;

  // Reset state, then extremes of the address, then the table special cases
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_ROW_COUNT] = '{
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd1, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd1, 1'b0, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd2048, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd2048, 1'b0, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd2048, 1'b1, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_DONE, 8'd0, 12'd2048, 1'b1, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd2048, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd2048, 1'b0, 1'b1, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd0, 1'b1, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_DONE, 8'd0, 12'd0, 1'b1, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd0, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd0, 1'b0, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd2049, 1'b1, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_DONE, 8'd0, 12'd2049, 1'b1, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd2049, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd2049, 1'b0, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd4095, 1'b1, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_DONE, 8'd0, 12'd4095, 1'b1, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd4095, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd4095, 1'b0, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd1, 1'b1, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_DONE, 8'd0, 12'd1, 1'b1, 1'b0, 1'b1}}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd1, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd1, 1'b0, 1'b0, 1'b1}}},
    // unsorted exact table with a repeated address
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_EXACT, 12'd100, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0,
      8'hA5, 1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_EXACT, 12'd100, 1'b0, 1'b0, 5'd1, 12'd0, 12'd0,
      8'h5A, 1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_EXACT, 12'd7, 1'b0, 1'b0, 5'd2, 12'd0, 12'd0,
      8'hFF, 1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_EXACT, 12'd100, 1'b0, 1'b0, 5'd3, 12'd0, 12'd0,
      8'h00, 1'b0, NO_BEAT}},
    // plain, inverted, beyond the table, and full-span ranges
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_RANGE, 12'd0, 1'b0, 1'b0, 5'd0, 12'd90, 12'd110,
      8'h11, 1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_RANGE, 12'd0, 1'b0, 1'b0, 5'd1, 12'd110, 12'd90,
      8'h22, 1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_RANGE, 12'd0, 1'b0, 1'b0, 5'd31, 12'd0, 12'd4095,
      8'h33, 1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_LOAD_RANGE, 12'd0, 1'b0, 1'b0, 5'd2, 12'd0, 12'd4095,
      8'h44, 1'b0, NO_BEAT}},
    '{ROW_COUNTS, 6'd4, 6'd3, NO_ITEM},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd100, 1'b0, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd7, 1'b1, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd4095, 1'b1, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b0, NO_BEAT}},
    // counts above the table depth
    '{ROW_COUNTS, 6'd63, 6'd31, NO_ITEM},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_REQUEST, 12'd100, 1'b1, 1'b1, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b0, NO_BEAT}},
    '{ROW_SEND, 6'd0, 6'd0, '{KIND_QUERY, 12'd100, 1'b0, 1'b0, 5'd0, 12'd0, 12'd0, 8'd0,
      1'b1, '{RES_STATE, 8'd0, 12'd100, 1'b0, 1'b1, 1'b1}}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_EXACT_COUNT;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          kind = KIND_REQUEST;
  logic [ADDR_W-1:0]   address = '0;
  logic                direction = 1'b0;
  logic                on_flag = 1'b0;
  logic [SLOT_W-1:0]   entry_slot = '0;
  logic [ADDR_W-1:0]   range_first = '0;
  logic [ADDR_W-1:0]   range_last = '0;
  logic [SUB_W-1:0]    subscriber_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          result_kind;
  logic [SUB_W-1:0]    subscriber;
  logic [ADDR_W-1:0]   switch_address;
  logic                switch_direction;
  logic                state_bit;
  logic                last;

  // Predictor copy of the block state
  bit                  direction_mem [1:SWITCH_COUNT_DEF];
  logic [ADDR_W-1:0]   exact_addr_mem [EXACT_ENTRIES_DEF];
  logic [SUB_W-1:0]    exact_sub_mem [EXACT_ENTRIES_DEF];
  logic [ADDR_W-1:0]   range_lo_mem [RANGE_ENTRIES_DEF];
  logic [ADDR_W-1:0]   range_hi_mem [RANGE_ENTRIES_DEF];
  logic [SUB_W-1:0]    range_sub_mem [RANGE_ENTRIES_DEF];
  int unsigned         exact_count_reg = 0;
  int unsigned         range_count_reg = 0;

  switch_item_t        pending_items [$];
  switch_item_t        current_item;
  out_beat_t           routed_beats [$];
  out_beat_t           expected_beats [$];

  int                  in_idle_pct = IDLE_PCT;
  int                  out_idle_pct = IDLE_PCT;
  int                  items_sent = 0;
  int                  beats_seen = 0;
  int                  exact_hits = 0;
  int                  range_hits = 0;
  int                  mismatches = 0;

  switch_request_router i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .address          (address),
    .direction        (direction),
    .on_flag          (on_flag),
    .entry_slot       (entry_slot),
    .range_first      (range_first),
    .range_last       (range_last),
    .subscriber_id    (subscriber_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .subscriber       (subscriber),
    .switch_address   (switch_address),
    .switch_direction (switch_direction),
    .state_bit        (state_bit),
    .last             (last)
  );

  always #2 clk = ~clk;

  function automatic out_beat_t make_beat(input result_kind_t rk, input logic [SUB_W-1:0] sub,
                                          input logic [ADDR_W-1:0] adr, input logic dir,
                                          input logic sb, input logic lst);
    out_beat_t b;
    b.result_kind = rk;
    b.subscriber = sub;
    b.switch_address = adr;
    b.switch_direction = dir;
    b.state_bit = sb;
    b.last = lst;
    return b;
  endfunction

  // Update the state copy for one item and list the beats it produces
  function automatic void route_item(input switch_item_t it);
    int unsigned limit;
    logic        stored;
    routed_beats.delete();
    case (it.kind)
      KIND_LOAD_EXACT: begin
        exact_addr_mem[it.entry_slot] = it.address;
        exact_sub_mem[it.entry_slot] = it.subscriber_id;
      end
      KIND_LOAD_RANGE: begin
        if (it.entry_slot < RANGE_ENTRIES_DEF) begin
          range_lo_mem[it.entry_slot] = it.range_first;
          range_hi_mem[it.entry_slot] = it.range_last;
          range_sub_mem[it.entry_slot] = it.subscriber_id;
        end
      end
      KIND_QUERY: begin
        stored = 1'b0;
        if (it.address >= 1 && it.address <= SWITCH_COUNT_DEF) stored = direction_mem[it.address];
        routed_beats.push_back(make_beat(RES_STATE, '0, it.address, 1'b0, stored, 1'b1));
      end
      default: begin
        if (it.on_flag) begin
          if (it.address >= 1 && it.address <= SWITCH_COUNT_DEF) begin
            direction_mem[it.address] = it.direction;
          end
          limit = (exact_count_reg > EXACT_ENTRIES_DEF) ? EXACT_ENTRIES_DEF : exact_count_reg;
          for (int i = 0; i < limit; i++) begin
            if (exact_addr_mem[i] == it.address) begin
              routed_beats.push_back(make_beat(RES_EXACT, exact_sub_mem[i], it.address,
                                               it.direction, 1'b0, 1'b0));
            end
          end
          limit = (range_count_reg > RANGE_ENTRIES_DEF) ? RANGE_ENTRIES_DEF : range_count_reg;
          for (int i = 0; i < limit; i++) begin
            if (it.address >= range_lo_mem[i] && it.address <= range_hi_mem[i]) begin
              routed_beats.push_back(make_beat(RES_RANGE, range_sub_mem[i], it.address,
                                               it.direction, 1'b0, 1'b0));
            end
          end
        end
        routed_beats.push_back(make_beat(RES_DONE, '0, it.address, it.direction, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // Bias addresses toward loaded entries, a small hot set and the range edges
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return exact_addr_mem[$urandom_range(EXACT_ENTRIES_DEF - 1)];
    if (roll < 70) return ADDR_W'($urandom_range(24, 1));
    if (roll < 85) begin
      case ($urandom_range(4))
        0: return '0;
        1: return ADDR_W'(1);
        2: return ADDR_W'(SWITCH_COUNT_DEF);
        3: return ADDR_W'(SWITCH_COUNT_DEF + 1);
        default: return '1;
      endcase
    end
    return ADDR_W'($urandom);
  endfunction

  function automatic switch_item_t random_item();
    switch_item_t it;
    int unsigned  roll;
    roll = $urandom_range(99);
    if (roll < 45) it.kind = KIND_REQUEST;
    else if (roll < 75) it.kind = KIND_QUERY;
    else if (roll < 88) it.kind = KIND_LOAD_EXACT;
    else it.kind = KIND_LOAD_RANGE;
    it.address = pick_address();
    it.direction = 1'($urandom_range(1));
    it.on_flag = ($urandom_range(9) != 0);
    if (it.kind == KIND_LOAD_RANGE && $urandom_range(9) < 8) begin
      it.entry_slot = SLOT_W'($urandom_range(RANGE_ENTRIES_DEF - 1));
    end else begin
      it.entry_slot = SLOT_W'($urandom);
    end
    if ($urandom_range(3) == 0) begin
      it.range_first = ADDR_W'($urandom);
      it.range_last = ADDR_W'($urandom);
    end else begin
      it.range_first = ADDR_W'($urandom_range(20));
      it.range_last = it.range_first + ADDR_W'($urandom_range(30));
    end
    it.subscriber_id = SUB_W'($urandom);
    it.typed = 1'b0;
    it.result = NO_BEAT;
    return it;
  endfunction

  // Input side: predict the accepted beat, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        route_item(current_item);
        if (current_item.typed) begin
          expected_beats.push_back(current_item.result);
        end else begin
          foreach (routed_beats[i]) expected_beats.push_back(routed_beats[i]);
        end
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          current_item = pending_items.pop_front();
          in_valid <= 1'b1;
          kind <= current_item.kind;
          address <= current_item.address;
          direction <= current_item.direction;
          on_flag <= current_item.on_flag;
          entry_slot <= current_item.entry_slot;
          range_first <= current_item.range_first;
          range_last <= current_item.range_last;
          subscriber_id <= current_item.subscriber_id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest expected one
  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    string     diff;
    if (!rst && out_valid && out_ready) begin
      got = make_beat(result_kind_t'(result_kind), subscriber, switch_address,
                      switch_direction, state_bit, last);
      beats_seen++;
      if (got.result_kind == RES_EXACT) exact_hits++;
      if (got.result_kind == RES_RANGE) range_hits++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected beat kind=%0d sub=%h adr=%0d dir=%b bit=%b last=%b",
                   $realtime, got.result_kind, got.subscriber, got.switch_address,
                   got.switch_direction, got.state_bit, got.last);
        end
      end else begin
        want = expected_beats.pop_front();
        diff = "";
        if (got.result_kind !== want.result_kind) diff = {diff, " result_kind"};
        if (got.subscriber !== want.subscriber) diff = {diff, " subscriber"};
        if (got.switch_address !== want.switch_address) diff = {diff, " switch_address"};
        if (got.switch_direction !== want.switch_direction) diff = {diff, " switch_direction"};
        if (got.state_bit !== want.state_bit) diff = {diff, " state_bit"};
        if (got.last !== want.last) diff = {diff, " last"};
        if (diff != "") begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: beat %0d differs in%s", $realtime, beats_seen, diff);
            $display("  exp kind=%0d sub=%h adr=%0d dir=%b bit=%b last=%b",
                     want.result_kind, want.subscriber, want.switch_address,
                     want.switch_direction, want.state_bit, want.last);
            $display("  got kind=%0d sub=%h adr=%0d dir=%b bit=%b last=%b",
                     got.result_kind, got.subscriber, got.switch_address,
                     got.switch_direction, got.state_bit, got.last);
          end
        end
      end
    end
  end

  // Wait until every beat is accepted and answered, then let loads finish
  task automatic settle(input int tail);
    while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(posedge clk);
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_counts(input logic [5:0] exact_n, input logic [5:0] range_n);
    cfg_we <= 1'b1;
    cfg_index <= CFG_EXACT_COUNT;
    cfg_data <= exact_n;
    @(posedge clk);
    cfg_index <= CFG_RANGE_COUNT;
    cfg_data <= range_n;
    @(posedge clk);
    cfg_we <= 1'b0;
    exact_count_reg = exact_n;
    range_count_reg = range_n[4:0];
  endtask

  initial begin
    switch_item_t it;
    logic [5:0]   exact_n;
    logic [5:0]   range_n;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Load every table entry while the counts are still zero
    for (int s = 0; s < EXACT_ENTRIES_DEF; s++) begin
      it = random_item();
      it.kind = KIND_LOAD_EXACT;
      it.entry_slot = SLOT_W'(s);
      pending_items.push_back(it);
    end
    for (int s = 0; s < RANGE_ENTRIES_DEF; s++) begin
      it = random_item();
      it.kind = KIND_LOAD_RANGE;
      it.entry_slot = SLOT_W'(s);
      pending_items.push_back(it);
    end

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].op == ROW_COUNTS) begin
        settle(SETTLE_CYCLES);
        set_counts(DIRECTED_ROWS[r].exact_n, DIRECTED_ROWS[r].range_n);
      end else begin
        pending_items.push_back(DIRECTED_ROWS[r].item);
      end
    end

    // Random phases, each under its own pair of counts
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle(SETTLE_CYCLES);
      if (p < FIXED_PHASES) begin
        exact_n = 6'(PHASE_EXACT[p]);
        range_n = 6'(PHASE_RANGE[p]);
      end else begin
        exact_n = 6'($urandom_range(63));
        range_n = 6'($urandom_range(31));
      end
      set_counts(exact_n, range_n);
      in_idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
      out_idle_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
      repeat (PHASE_ITEMS) pending_items.push_back(random_item());
    end

    settle(TAIL_CYCLES);
    $display("sent %0d input beats under %0d count settings; checked %0d result beats",
             items_sent, PHASE_COUNT + 2, beats_seen);
    $display("%0d exact and %0d range matches, %0d mismatches",
             exact_hits, range_hits, mismatches);
    if (mismatches == 0) begin
      $display("tb_switch_request_router passed");
    end else begin
      $display("tb_switch_request_router failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("run timed out with %0d beats still expected", expected_beats.size());
    $display("tb_switch_request_router failed");
    $finish;
  end

endmodule
